### hdl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the polar frame transform
// Fixed widths of the CORDIC datapath, the arctangent table, the gain
// compensation constant and the configuration register indexes.
// ----------------------------------------------------------------------------
package pft_pkg;

	// Field widths
	localparam int RANGE_W    = 16;
	localparam int ANGLE_IN_W = 16;
	localparam int OUT_RNG_W  = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Datapath widths: coordinates carry FRAC_BITS fraction bits
	localparam int FRAC_BITS = 14;
	localparam int ROT_W     = 32;	// rotation chain x/y
	localparam int VEC_W     = 34;	// vectoring chain x/y, offset added
	localparam int ANGLE_W   = 32;	// 2^-32 turn units, wraps

	// Gain compensation: 1/K in Q30, rounded by adding half an LSB
	localparam int GAIN_W     = 30;
	localparam int GAIN_SHIFT = 30;
	localparam logic [GAIN_W-1:0] GAIN_INV = 30'd652032874;
	localparam logic [GAIN_SHIFT-1:0] GAIN_HALF = 30'd536870912;

	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i) in 2^-32 turn units
	localparam int ATAN_DEPTH = 24;
	localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW      = 2'd2;

	// Control that travels alongside each point through the pipeline
	typedef struct packed {
		logic valid;
		logic zero;	// vector was zero after the offset add
	} pft_side_t;

endpackage

### hdl/polar_frame_transform.sv
// ----------------------------------------------------------------------------
// polar_frame_transform: sensor polar point to robot polar point
// Pipeline: input register, NS rotation cells (CORDIC_STAGES capped at
// 24), three gain/offset stages, NS vectoring cells, three gain/round
// stages; done rises once a request has passed through all of them.
// Throughput: one point per cycle, busy stays low.
// Reset clears the mount registers to zero and drops every point in flight.
// Results cannot be stalled: each is on the ports for exactly one cycle.
// ----------------------------------------------------------------------------
module polar_frame_transform
	import pft_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [RANGE_W-1:0]           point_range,
	input  logic signed [ANGLE_IN_W-1:0] point_bearing,
	output logic                         done,
	output logic [OUT_RNG_W-1:0]         robot_range,
	output logic signed [ANGLE_IN_W-1:0] robot_bearing,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int NS = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
	localparam int ROT_P_W = ROT_W + GAIN_W + 1;
	localparam int VEC_P_W = ANGLE_W + GAIN_W + 1;
	localparam int VEC_C_W = VEC_P_W - GAIN_SHIFT;
	localparam int RND_W   = VEC_C_W + 1;
	localparam logic [OUT_RNG_W-1:0] RANGE_MAX = '1;

	// Mount registers
	logic signed [CFG_DATA_W-1:0] off_x_q;
	logic signed [CFG_DATA_W-1:0] off_y_q;
	logic signed [CFG_DATA_W-1:0] yaw_q;

	// Input stage
	logic                         accept;
	logic signed [ANGLE_IN_W-1:0] turn;
	logic                         fold;
	logic [ANGLE_IN_W-1:0]        turn_f;
	logic signed [ROT_W-1:0]      range_x;
	pft_side_t                    side_s0;
	logic signed [ROT_W-1:0]      x_s0;
	logic [ANGLE_W-1:0]           z_s0;

	// Rotation chain
	pft_side_t               rside [0:NS];
	logic signed [ROT_W-1:0] rx    [0:NS];
	logic signed [ROT_W-1:0] ry    [0:NS];
	logic [ANGLE_W-1:0]      rz    [0:NS-1];

	// Gain compensation and offset
	pft_side_t                 side_s1;
	logic signed [ROT_P_W-1:0] px_s1;
	logic signed [ROT_P_W-1:0] py_s1;
	logic signed [ROT_P_W-1:0] px_rnd;
	logic signed [ROT_P_W-1:0] py_rnd;
	pft_side_t                 side_s2;
	logic signed [VEC_W-1:0]   xo_s2;
	logic signed [VEC_W-1:0]   yo_s2;
	pft_side_t                 side_s3;
	logic signed [VEC_W-1:0]   vx_s3;
	logic signed [VEC_W-1:0]   vy_s3;
	logic [ANGLE_W-1:0]        vz_s3;

	// Vectoring chain
	pft_side_t               vside [0:NS];
	logic signed [VEC_W-1:0] vx    [0:NS];
	logic signed [VEC_W-1:0] vy    [0:NS-1];
	logic [ANGLE_W-1:0]      vz    [0:NS];

	// Output stages
	pft_side_t                side_s4;
	logic [VEC_P_W-2:0]       pr_s4;
	logic [ANGLE_W-1:0]       z_s4;
	logic [VEC_P_W-1:0]       pr_rnd;
	pft_side_t                side_s5;
	logic [VEC_C_W-1:0]       g_s5;
	logic [ANGLE_W-1:0]       z_s5;
	logic [RND_W-1:0]         g_rnd;
	logic [RND_W-FRAC_BITS-1:0] rng_full;
	logic [ANGLE_W-1:0]       z_rnd;
	logic                     done_s6;
	logic [OUT_RNG_W-1:0]     range_s6;
	logic [ANGLE_IN_W-1:0]    bearing_s6;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Write the mount registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			yaw_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OFFSET_X: off_x_q <= cfg_data;
				REG_OFFSET_Y: off_y_q <= cfg_data;
				REG_YAW:      yaw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fold the start angle into [-quarter, quarter) and negate the vector
	assign turn    = point_bearing + yaw_q;
	assign fold    = turn[ANGLE_IN_W-1] ^ turn[ANGLE_IN_W-2];
	assign turn_f  = {turn[ANGLE_IN_W-1] ^ fold, turn[ANGLE_IN_W-2:0]};
	assign range_x = ROT_W'({point_range, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s0 <= '0;
		end else begin
			side_s0 <= '{valid: accept, zero: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= fold ? -range_x : range_x;
		z_s0 <= {turn_f, {(ANGLE_W-ANGLE_IN_W){1'b0}}};
	end

	// Rotate (range, 0) by the folded angle
	assign rside[0] = side_s0;
	assign rx[0]    = x_s0;
	assign ry[0]    = '0;
	assign rz[0]    = z_s0;

	for (genvar i = 0; i < NS; i++) begin : g_rot
		if (i == NS - 1) begin : g_last
			pft_cell #(.W(ROT_W), .IDX(i), .VECTOR(1'b0)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_side(rside[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]),
				.out_side(rside[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]), .out_z()
			);
		end else begin : g_mid
			pft_cell #(.W(ROT_W), .IDX(i), .VECTOR(1'b0)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_side(rside[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]),
				.out_side(rside[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]),
				.out_z(rz[i+1])
			);
		end
	end

	// Multiply by the inverse gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s1 <= rside[NS];
			side_s2 <= side_s1;
			side_s3 <= '{valid: side_s2.valid,
				zero: (xo_s2 == '0) && (yo_s2 == '0)};
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= ROT_P_W'(rx[NS]) * ROT_P_W'($signed({1'b0, GAIN_INV}));
		py_s1 <= ROT_P_W'(ry[NS]) * ROT_P_W'($signed({1'b0, GAIN_INV}));
	end

	// Round and add the mount offset
	assign px_rnd = px_s1 + ROT_P_W'(GAIN_HALF);
	assign py_rnd = py_s1 + ROT_P_W'(GAIN_HALF);

	always_ff @(posedge clk) begin
		xo_s2 <= VEC_W'($signed(px_rnd[ROT_P_W-1:GAIN_SHIFT]))
			+ VEC_W'($signed({off_x_q, {FRAC_BITS{1'b0}}}));
		yo_s2 <= VEC_W'($signed(py_rnd[ROT_P_W-1:GAIN_SHIFT]))
			+ VEC_W'($signed({off_y_q, {FRAC_BITS{1'b0}}}));
	end

	// Move the vector into the right half plane
	always_ff @(posedge clk) begin
		if (xo_s2[VEC_W-1]) begin
			vx_s3 <= -xo_s2;
			vy_s3 <= -yo_s2;
			vz_s3 <= HALF_TURN;
		end else begin
			vx_s3 <= xo_s2;
			vy_s3 <= yo_s2;
			vz_s3 <= '0;
		end
	end

	// Vector the shifted point onto the x axis
	assign vside[0] = side_s3;
	assign vx[0]    = vx_s3;
	assign vy[0]    = vy_s3;
	assign vz[0]    = vz_s3;

	for (genvar i = 0; i < NS; i++) begin : g_vec
		if (i == NS - 1) begin : g_last
			pft_cell #(.W(VEC_W), .IDX(i), .VECTOR(1'b1)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_side(vside[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]),
				.out_side(vside[i+1]), .out_x(vx[i+1]), .out_y(), .out_z(vz[i+1])
			);
		end else begin : g_mid
			pft_cell #(.W(VEC_W), .IDX(i), .VECTOR(1'b1)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_side(vside[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]),
				.out_side(vside[i+1]), .out_x(vx[i+1]), .out_y(vy[i+1]),
				.out_z(vz[i+1])
			);
		end
	end

	// Compensate the range; x is never negative here and fits 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
			done_s6 <= 1'b0;
		end else begin
			side_s4 <= vside[NS];
			side_s5 <= side_s4;
			done_s6 <= side_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		pr_s4 <= (VEC_P_W-1)'(vx[NS][ANGLE_W-1:0]) * (VEC_P_W-1)'(GAIN_INV);
		z_s4  <= vz[NS];
	end

	assign pr_rnd = {1'b0, pr_s4} + VEC_P_W'(GAIN_HALF);

	always_ff @(posedge clk) begin
		g_s5 <= pr_rnd[VEC_P_W-1:GAIN_SHIFT];
		z_s5 <= z_s4;
	end

	// Round to whole units, saturate, round the bearing
	assign g_rnd    = RND_W'(g_s5) + RND_W'(1 << (FRAC_BITS - 1));
	assign rng_full = g_rnd[RND_W-1:FRAC_BITS];
	assign z_rnd    = z_s5 + ANGLE_W'(1 << (ANGLE_W - ANGLE_IN_W - 1));

	always_ff @(posedge clk) begin
		if (rng_full > (RND_W-FRAC_BITS)'(RANGE_MAX)) begin
			range_s6 <= RANGE_MAX;
		end else begin
			range_s6 <= rng_full[OUT_RNG_W-1:0];
		end
		if (side_s5.zero) begin
			bearing_s6 <= '0;
		end else begin
			bearing_s6 <= z_rnd[ANGLE_W-1:ANGLE_W-ANGLE_IN_W];
		end
	end

	assign done          = done_s6;
	assign robot_range   = range_s6;
	assign robot_bearing = bearing_s6;

`ifndef SYNTH
	// Folded start angle lies within a quarter turn of zero
	a_start_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		side_s0.valid |-> (z_s0[ANGLE_W-1] == z_s0[ANGLE_W-2]))
		else $error("rotation start angle outside a quarter turn");

	// Vectoring starts in the right half plane
	a_vec_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		side_s3.valid |-> !vx_s3[VEC_W-1])
		else $error("vectoring start x is negative");

	// Zero flag is set only on a zero vector
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(side_s3.valid && side_s3.zero) |-> (vx_s3 == '0 && vy_s3 == '0))
		else $error("zero flag set on a nonzero vector");

	// Final vectoring magnitude fits the unsigned multiplier input
	a_vec_end_fit: assert property (@(posedge clk) disable iff (!arst_n)
		vside[NS].valid |-> (vx[NS][VEC_W-1:ANGLE_W] == '0))
		else $error("vectoring magnitude exceeds 32 bits");
`endif

endmodule

### hdl/pft_cell.sv
// ----------------------------------------------------------------------------
// pft_cell: one CORDIC micro-rotation
// Rotates (x, y) by +/- atan(2^-IDX) and updates the angle accumulator.
// Rotation mode steers by the sign of z, vectoring mode by the sign of y.
// Results are registered and handed to the next cell every cycle.
// ----------------------------------------------------------------------------
module pft_cell
	import pft_pkg::*;
#(
	parameter int W      = 32,
	parameter int IDX    = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pft_side_t           in_side,
	input  logic signed [W-1:0] in_x,
	input  logic signed [W-1:0] in_y,
	input  logic [ANGLE_W-1:0]  in_z,
	output pft_side_t           out_side,
	output logic signed [W-1:0] out_x,
	output logic signed [W-1:0] out_y,
	output logic [ANGLE_W-1:0]  out_z
);

	localparam logic [ANGLE_W-1:0] ATAN = ATAN_TAB[IDX];

	logic                ccw;
	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic signed [W-1:0] nx;
	logic signed [W-1:0] ny;
	logic [ANGLE_W-1:0]  nz;

	pft_side_t           side_q;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic [ANGLE_W-1:0]  z_q;

	// Pick the turn direction
	assign ccw = VECTOR ? in_y[W-1] : ~in_z[ANGLE_W-1];
	assign xs  = in_x >>> IDX;
	assign ys  = in_y >>> IDX;

	// Micro-rotation
	always_comb begin
		if (ccw) begin
			nx = in_x - ys;
			ny = in_y + xs;
			nz = in_z - ATAN;
		end else begin
			nx = in_x + ys;
			ny = in_y - xs;
			nz = in_z + ATAN;
		end
	end

	// Advance the control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= in_side;
		end
	end

	// Advance the data
	always_ff @(posedge clk) begin
		x_q <= nx;
		y_q <= ny;
		z_q <= nz;
	end

	assign out_side = side_q;
	assign out_x    = x_q;
	assign out_y    = y_q;
	assign out_z    = z_q;

endmodule

### tb/sv/tb_polar_frame_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_frame_transform: self-checking bench for the polar frame transform
// Sends sensor polar points and predicts each robot polar result with an
// integer CORDIC model kept inside the bench. Every result is compared field
// by field with the oldest prediction. Covers the reset mount, extreme mount
// settings and random settings. Requests come in random bursts, gaps optional.
// ----------------------------------------------------------------------------
module tb_polar_frame_transform;
	import pft_pkg::*;

	localparam int NSTAGES   = 16;
	localparam int STAGE_CNT = (NSTAGES > 24) ? 24 : NSTAGES;
	localparam int LATENCY   = 2 * NSTAGES + 6;
	localparam int LIMIT     = 400000;
	localparam int FRAC      = 14;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam longint HALF_REV = 64'd2147483648;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// atan(2^-i) in 2^-32 turn units
	localparam longint ARCTAN [24] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
	};

	typedef struct packed {
		logic [OUT_RNG_W-1:0]  rng;
		logic [ANGLE_IN_W-1:0] brg;
	} robot_pt_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [RANGE_W-1:0]           point_range;
	logic signed [ANGLE_IN_W-1:0] point_bearing;
	logic                         done;
	logic [OUT_RNG_W-1:0]         robot_range;
	logic signed [ANGLE_IN_W-1:0] robot_bearing;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;

	// Mount registers as the bench believes them to be
	logic signed [15:0] off_x;
	logic signed [15:0] off_y;
	logic signed [15:0] yaw_q;

	robot_pt_t robot_pt_q [$];
	int        err_count;
	int        items_sent;
	int        results_seen;
	int        reg_writes;
	int        mount_settings;
	int        cycle_cnt;
	int        burst_left;
	bit        gaps_on;

	polar_frame_transform #(
		.CORDIC_STAGES(NSTAGES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.point_range  (point_range),
		.point_bearing(point_bearing),
		.done         (done),
		.robot_range  (robot_range),
		.robot_bearing(robot_bearing),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Multiply by 1/K in Q30 with round half up
	function automatic longint unity_gain(longint v);
		return (v * GAIN_Q30 + 64'sd536870912) >>> 30;
	endfunction

	// Rotate by bearing + yaw, add the mount offset, convert back to polar
	function automatic robot_pt_t transform_point(logic [RANGE_W-1:0] rng_in,
			logic [ANGLE_IN_W-1:0] brg_in);
		logic [15:0] t16;
		longint t, x, y, z, nx, ny, rng, brg;
		robot_pt_t res;
		t16 = brg_in + yaw_q;
		t = longint'($signed(t16));
		x = longint'(rng_in) <<< FRAC;
		y = 0;
		// fold the angle into the right half plane
		if (t >= 16384) begin
			t -= 32768;
			x = -x;
		end else if (t < -16384) begin
			t += 32768;
			x = -x;
		end
		z = t * 65536;
		for (int i = 0; i < STAGE_CNT; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
			y = ny;
		end
		x = unity_gain(x) + (longint'(off_x) <<< FRAC);
		y = unity_gain(y) + (longint'(off_y) <<< FRAC);
		// zero vector gives zero range and zero bearing
		if (x == 0 && y == 0) begin
			res.rng = '0;
			res.brg = '0;
			return res;
		end
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_REV;
		end
		for (int i = 0; i < STAGE_CNT; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
			y = ny;
		end
		rng = (unity_gain(x) + 64'd8192) >>> FRAC;
		if (rng < 0)
			rng = 0;
		if (rng > 131071)
			rng = 131071;
		brg = (z + 64'd32768) >>> 16;
		res.rng = rng[OUT_RNG_W-1:0];
		res.brg = brg[ANGLE_IN_W-1:0];
		return res;
	endfunction

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Write one mount register and track it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OFFSET_X: off_x = val;
			REG_OFFSET_Y: off_y = val;
			REG_YAW:      yaw_q = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mount(input logic [15:0] ox, input logic [15:0] oy,
			input logic [15:0] yw);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_YAW, yw);
		mount_settings++;
	endtask

	// Send one request; open a new burst, with a gap if enabled
	task automatic send_point(input logic [RANGE_W-1:0] r, input logic [ANGLE_IN_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (gaps_on) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start         <= 1'b1;
		point_range   <= r;
		point_bearing <= b;
		do @(posedge clk); while (busy);
		robot_pt_q.push_back(transform_point(r, b));
		items_sent++;
	endtask

	// Drop start and drain the pipeline
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (robot_pt_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		burst_left = 0;
	endtask

	// Points with the mount at its reset value
	task automatic test_reset_mount();
		send_point(16'd0, 16'h0000);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'hFFFF, 16'h3FFF);
		send_point(16'hFFFF, 16'h4000);
		send_point(16'hFFFF, 16'hC000);
		send_point(16'hFFFF, 16'hBFFF);
		send_point(16'hFFFF, 16'h8000);
		send_point(16'hFFFF, 16'h7FFF);
		send_point(16'd1, 16'h0001);
		send_point(16'd12345, 16'hE000);
		wait_idle();
	endtask

	// Extreme mounts: pure offset, negative x after offset, largest range
	task automatic test_mount_extremes();
		set_mount(16'h7FFF, 16'h7FFF, 16'h8000);
		send_point(16'd0, 16'h1234);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'hFFFF, 16'h7FFF);
		wait_idle();
		set_mount(16'h8000, 16'h0000, 16'h0000);
		send_point(16'd0, 16'h0000);
		send_point(16'd32768, 16'h0000);
		send_point(16'd32768, 16'h8000);
		wait_idle();
		set_mount(16'h7FFF, 16'h7FFF, 16'h2000);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'hFFFF, 16'h8000);
		wait_idle();
		// index beyond the last register must leave the mount alone
		write_reg(REG_UNUSED, 16'($urandom));
		send_point(16'hFFFF, 16'h0000);
		wait_idle();
		set_mount(16'h8000, 16'h8000, 16'h7FFF);
		send_point(16'd0, 16'h0000);
		send_point(16'hFFFF, 16'h4001);
		wait_idle();
	endtask

	// Random point, biased toward zero, full scale and the fold points
	task automatic rand_point(output logic [RANGE_W-1:0] r, output logic [ANGLE_IN_W-1:0] b);
		logic [15:0] fold_pts [7];
		int sel;
		fold_pts = '{16'h4000, 16'h3FFF, 16'hC000, 16'hBFFF, 16'h8000, 16'h7FFF, 16'h0000};
		sel = $urandom_range(0, 9);
		case (sel)
			0: r = '0;
			1: r = '1;
			2: r = 16'($urandom_range(0, 255));
			default: r = 16'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0)
			b = fold_pts[$urandom_range(0, 6)] - yaw_q + 16'($urandom_range(0, 6)) - 16'd3;
		else
			b = 16'($urandom);
	endtask

	// Random points under extreme and random mount settings
	task automatic test_random_sweep();
		logic [RANGE_W-1:0] r;
		logic [ANGLE_IN_W-1:0] b;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_mount(16'h7FFF, 16'h7FFF, 16'h7FFF);
				1: set_mount(16'h8000, 16'h8000, 16'h8000);
				2: set_mount(16'h0000, 16'h0000, 16'h4000);
				default: set_mount(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (312) begin
				rand_point(r, b);
				send_point(r, b);
			end
			wait_idle();
		end
		gaps_on = 1'b1;
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		robot_pt_t exp_pt;
		if (arst_n && done) begin
			if (robot_pt_q.size() == 0) begin
				report_error($sformatf("result with nothing expected: range %0d bearing %0d",
					robot_range, robot_bearing));
			end else begin
				exp_pt = robot_pt_q.pop_front();
				results_seen++;
				if (robot_range !== exp_pt.rng)
					report_error($sformatf("robot_range exp %0d got %0d",
						exp_pt.rng, robot_range));
				if (robot_bearing !== exp_pt.brg)
					report_error($sformatf("robot_bearing exp %0d got %0d",
						$signed(exp_pt.brg), robot_bearing));
			end
		end
	end

	// Watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_cnt, robot_pt_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		point_range    = '0;
		point_bearing  = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		off_x          = '0;
		off_y          = '0;
		yaw_q          = '0;
		err_count      = 0;
		items_sent     = 0;
		results_seen   = 0;
		reg_writes     = 0;
		mount_settings = 1;
		burst_left     = 0;
		gaps_on        = 1'b1;
		// hold reset, then release it at a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_mount();
		test_mount_extremes();
		test_random_sweep();
		wait_idle();

		if (robot_pt_q.size() != 0)
			report_error($sformatf("%0d results never arrived", robot_pt_q.size()));
		$display("covered %0d points, %0d results checked, %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("%0d mount settings, %0d errors", mount_settings, err_count);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
